@@ rtl/line_editor_with_echo_core_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the line editor RTL.
// Each macro expects clk and rst_n in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef LINE_EDITOR_WITH_ECHO_CORE_ASSERT_SVH
`define LINE_EDITOR_WITH_ECHO_CORE_ASSERT_SVH

// same-cycle implication
`define LEC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LEC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lec_pkg.sv @@
// ---------------------------------------------------------------------------
// lec_pkg
// Types and constants shared by the terminal line editor modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lec_pkg;

  localparam int CFG_W   = 5;  // max_delivered_chars width
  localparam int IDX_W   = 6;  // covers every supported line size
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_W-1:0] MAX_CHARS_RST = 5'd31;

  // result kinds
  localparam logic [1:0] KIND_ECHO = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_END  = 2'd2;

  // byte codes
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_ZERO  = 8'h00;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_ERASE = 2'd1,
    OP_LINE  = 2'd2
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t          op;
    logic             echo;
    logic [6:0]       data;   // character to store
    logic [IDX_W-1:0] idx;    // store position
    logic [CFG_W-1:0] count;  // characters to deliver
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/lec_front.sv @@
// ---------------------------------------------------------------------------
// lec_front
// Classifies received bytes, tracks the line length and issues commands.
// ---------------------------------------------------------------------------
`default_nettype none

module lec_front #(
  parameter int LINE_BYTES = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_rx_byte,
  input  wire logic                      in_host_connected,
  input  wire logic [lec_pkg::CFG_W-1:0] max_chars,
  input  wire logic                      q_full,
  output logic                           cmd_push,
  output lec_pkg::cmd_t                  cmd
);
  import lec_pkg::*;

  localparam int LW = $clog2(LINE_BYTES);
  localparam int CW = (LW > CFG_W) ? LW : CFG_W;
  localparam logic [LW-1:0] LEN_MAX = LW'(LINE_BYTES - 1);

  logic [LW-1:0] len_r, len_nxt;
  logic          accept;
  logic          is_eol, is_erase, is_print;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  assign is_eol   = (in_rx_byte == CH_CR) || (in_rx_byte == CH_LF);
  assign is_erase = (in_rx_byte == CH_BS) || (in_rx_byte == CH_DEL);
  assign is_print = (in_rx_byte >= CH_SP) && (in_rx_byte < CH_DEL);

  always_comb begin
    len_nxt   = len_r;
    cmd_push  = 1'b0;
    cmd.op    = OP_STORE;
    cmd.echo  = in_host_connected;
    cmd.data  = in_rx_byte[6:0];
    cmd.idx   = IDX_W'(len_r);
    cmd.count = (CW'(len_r) < CW'(max_chars)) ? CFG_W'(len_r) : max_chars;
    if (accept) begin
      if (is_eol) begin
        cmd.op   = OP_LINE;
        cmd_push = 1'b1;
        len_nxt  = '0;
      end else if (is_erase) begin
        if (len_r != '0) begin
          len_nxt  = len_r - LW'(1);
          cmd.op   = OP_ERASE;
          cmd_push = in_host_connected;  // silent erase needs no back-end work
        end
      end else if (is_print) begin
        if (len_r < LEN_MAX) begin
          len_nxt  = len_r + LW'(1);
          cmd_push = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/lec_fifo.sv @@
// ---------------------------------------------------------------------------
// lec_fifo
// Short command queue between the classifier and the output sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module lec_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire lec_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output lec_pkg::cmd_t      pop_data,
  output logic               not_empty
);
  import lec_pkg::*;

  `include "line_editor_with_echo_core_assert.svh"

  cmd_t            q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == Q_CW'(Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + Q_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  `LEC_ASSERT_IMP(a_no_overflow, push, !full, "push into full command queue")
  `LEC_ASSERT_IMP(a_no_underflow, pop, not_empty, "pop from empty command queue")
  `LEC_ASSERT_NXT(a_cnt_up, push && !pop, cnt_r == $past(cnt_r) + Q_CW'(1),
                  "queue count did not advance on push")

endmodule

`default_nettype wire

@@ rtl/lec_back.sv @@
// ---------------------------------------------------------------------------
// lec_back
// Executes commands: stores characters and sequences echo and line output.
// ---------------------------------------------------------------------------
`default_nettype none

module lec_back #(
  parameter int LINE_BYTES = 32
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  wire lec_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_item_kind,
  output logic [7:0]         out_data_byte,
  output logic               out_last_of_run
);
  import lec_pkg::*;

  `include "line_editor_with_echo_core_assert.svh"

  localparam int DEPTH = LINE_BYTES - 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SP   = 7'b0000010,
    S_BS2  = 7'b0000100,
    S_LF   = 7'b0001000,
    S_RD   = 7'b0010000,
    S_CH   = 7'b0100000,
    S_END  = 7'b1000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] pos_r, pos_nxt;
  logic [CFG_W-1:0] cnt_r, cnt_nxt;
  logic [6:0]       mem [DEPTH];
  logic [6:0]       rd_data_r;
  logic             mem_we, rd_en;

  logic             can_emit, emit;
  logic [1:0]       e_kind;
  logic [7:0]       e_data;
  logic             e_last;

  logic             out_valid_r;
  logic [1:0]       out_kind_r;
  logic [7:0]       out_data_r;
  logic             out_last_r;

  assign can_emit = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    cmd_pop   = 1'b0;
    mem_we    = 1'b0;
    rd_en     = 1'b0;
    emit      = 1'b0;
    e_kind    = KIND_ECHO;
    e_data    = CH_ZERO;
    e_last    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid && can_emit) begin
          cmd_pop = 1'b1;
          cnt_nxt = cmd.count;
          pos_nxt = '0;
          unique case (cmd.op)
            OP_STORE: begin
              mem_we = 1'b1;
              emit   = cmd.echo;
              e_data = {1'b0, cmd.data};
              e_last = 1'b1;
            end
            OP_ERASE: begin
              emit      = 1'b1;
              e_data    = CH_BS;
              state_nxt = S_SP;
            end
            OP_LINE: begin
              if (cmd.echo) begin
                emit      = 1'b1;
                e_data    = CH_CR;
                state_nxt = S_LF;
              end else begin
                state_nxt = (cmd.count == '0) ? S_END : S_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SP: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_data    = CH_SP;
          state_nxt = S_BS2;
        end
      end
      S_BS2: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_data    = CH_BS;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_LF: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_data    = CH_LF;
          state_nxt = (cnt_r == '0) ? S_END : S_RD;
        end
      end
      S_RD: begin
        rd_en     = 1'b1;
        pos_nxt   = pos_r + CFG_W'(1);
        state_nxt = S_CH;
      end
      S_CH: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = KIND_CHAR;
          e_data    = {1'b0, rd_data_r};
          state_nxt = (pos_r == cnt_r) ? S_END : S_RD;
        end
      end
      S_END: begin
        if (can_emit) begin
          emit      = 1'b1;
          e_kind    = KIND_END;
          e_last    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_data_r <= e_data;
      out_last_r <= e_last;
    end
  end

  // character store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(cmd.idx)] <= cmd.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[AW'(pos_r)];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_item_kind   = out_kind_r;
  assign out_data_byte   = out_data_r;
  assign out_last_of_run = out_last_r;

  `LEC_ASSERT_IMP(a_ch_pos, state_r == S_CH, (pos_r != '0) && (pos_r <= cnt_r),
                  "delivery position out of range")
  `LEC_ASSERT_NXT(a_rd_then_ch, state_r == S_RD, state_r == S_CH,
                  "read not followed by character output")
  `LEC_ASSERT_IMP(a_end_fmt, out_valid_r && (out_kind_r == KIND_END),
                  out_last_r && (out_data_r == CH_ZERO), "malformed line end marker")

endmodule

`default_nettype wire

@@ rtl/line_editor_with_echo_core.sv @@
// ---------------------------------------------------------------------------
// line_editor_with_echo_core
// Terminal line editor: stores printable bytes, handles erase, echoes, and
// delivers completed lines followed by a line end marker.
// ---------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+-------------------------------------------
//  in      | in_valid/in_stall  | in_rx_byte, in_host_connected
//  out     | out_valid/out_stall| out_item_kind, out_data_byte, out_last_of_run
//  cfg     | cfg_valid/cfg_ready| cfg_max_delivered_chars
//
//  The classifier takes one byte per cycle while the two-entry command queue
//  has room. The sequencer emits one echo result per cycle while out is not
//  stalled; each delivered line character needs a read state and then an
//  output state (registered character store read). An echoed character
//  passes the command queue and output register before it is valid on out.
//  Synchronous active-low reset clears line length, queue and sequencer;
//  max_delivered_chars resets to 31. No clearing pass is needed.
//  out_stall holds the output register; input stalls only on a full queue.
// ---------------------------------------------------------------------------
`default_nettype none

module line_editor_with_echo_core #(
  parameter int LINE_BYTES = 32
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [7:0]                in_rx_byte,
  input  wire logic                      in_host_connected,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic [1:0]                     out_item_kind,
  output logic [7:0]                     out_data_byte,
  output logic                           out_last_of_run,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [lec_pkg::CFG_W-1:0] cfg_max_delivered_chars
);
  import lec_pkg::*;

  logic [CFG_W-1:0] max_chars_r;
  logic             q_full, q_push, q_pop, q_not_empty;
  cmd_t             push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= MAX_CHARS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_chars_r <= cfg_max_delivered_chars;
    end
  end

  lec_front #(
    .LINE_BYTES (LINE_BYTES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .in_host_connected (in_host_connected),
    .max_chars         (max_chars_r),
    .q_full            (q_full),
    .cmd_push          (q_push),
    .cmd               (push_cmd)
  );

  lec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_cmd),
    .not_empty (q_not_empty)
  );

  lec_back #(
    .LINE_BYTES (LINE_BYTES)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (q_not_empty),
    .cmd             (pop_cmd),
    .cmd_pop         (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_item_kind   (out_item_kind),
    .out_data_byte   (out_data_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

`default_nettype wire
